// ----- rtl/core/hsrd_pkg.sv -----
`timescale 1ns / 1ps
package hsrd_pkg;

  localparam int unsigned FIFO_DEPTH    = 10;
  localparam int unsigned PAYLOAD_BYTES = 24;
  localparam int unsigned REC_BYTES     = 22;
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam int unsigned SLOT_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W         = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FILL_W        = 4;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POP  = 1'b1;
  localparam logic KIND_POP  = 1'b0;
  localparam logic KIND_DROP = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_GATHER
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] charge_level;
    logic [31:0] speed_bits;
    logic [31:0] odometer_bits;
    logic [31:0] shown_speed_bits;
    logic [47:0] station_address;
  } rec_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       charge_level;
    logic [31:0]       speed_bits;
    logic [31:0]       odometer_bits;
    logic [31:0]       shown_speed_bits;
    logic [47:0]       station_address;
    logic [FILL_W-1:0] fill_level;
  } out_beat_t;

  typedef struct packed {
    logic is_pop;
    rec_t rec;
  } cmd_t;

  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] cnt);
    return FILL_W'(cnt);
  endfunction

endpackage

// ----- rtl/core/hsrd_front.sv -----
`timescale 1ns / 1ps
module hsrd_front
  import hsrd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_beat_t item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       asm_q [REC_BYTES];
  logic [7:0]       asm_view [REC_BYTES];
  logic             is_byte;
  logic             last_byte;
  logic             store_byte;

  assign is_byte    = accept_i && (item_i.func == FUNC_BYTE);
  assign last_byte  = (idx_q == IDX_W'(PAYLOAD_BYTES - 1));
  assign store_byte = is_byte && (phase_q == PH_GATHER) && (idx_q < IDX_W'(REC_BYTES));

  // next state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    if (is_byte) begin
      case (phase_q)
        PH_SYNC2: begin
          phase_d = (item_i.rx_byte == SYNC_SECOND) ? PH_GATHER : PH_HUNT;
          idx_d   = '0;
        end
        PH_GATHER: begin
          if (last_byte) begin
            phase_d = PH_HUNT;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          phase_d = (item_i.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    asm_view = asm_q;
    if (store_byte) begin
      asm_view[idx_q] = item_i.rx_byte;
    end
    cmd_valid_o = 1'b0;
    cmd_o.is_pop = 1'b0;
    cmd_o.rec.charge_level     = {asm_view[1], asm_view[0]};
    cmd_o.rec.speed_bits       = {asm_view[7], asm_view[6], asm_view[5], asm_view[4]};
    cmd_o.rec.odometer_bits    = {asm_view[11], asm_view[10], asm_view[9], asm_view[8]};
    cmd_o.rec.shown_speed_bits = {asm_view[15], asm_view[14], asm_view[13], asm_view[12]};
    cmd_o.rec.station_address  = {asm_view[16], asm_view[17], asm_view[18],
                                  asm_view[19], asm_view[20], asm_view[21]};
    if (accept_i && (item_i.func == FUNC_POP)) begin
      cmd_valid_o  = 1'b1;
      cmd_o.is_pop = 1'b1;
    end else if (is_byte && (phase_q == PH_GATHER) && last_byte) begin
      cmd_valid_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      asm_q[idx_q] <= item_i.rx_byte;
    end
  end

`ifndef SYNTH
  a_record_only_in_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && !cmd_o.is_pop) |-> (phase_q == PH_GATHER && $past(phase_q) == PH_GATHER
                                        || idx_q == '0))
    else $error("record emitted outside payload gathering");
`endif

endmodule

// ----- rtl/core/hsrd_cmd_queue.sv -----
`timescale 1ns / 1ps
module hsrd_cmd_queue
  import hsrd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output cmd_t rd_data_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(wr_en_i && !rd_en_i))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !empty_o)
    else $error("command queue underflow");
`endif

endmodule

// ----- rtl/core/hsrd_back.sv -----
`timescale 1ns / 1ps
module hsrd_back
  import hsrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_take_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_beat_t result_o
);

  rec_t              store_q [FIFO_DEPTH];
  logic [SLOT_W-1:0] rd_q, wr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q;
  out_beat_t         out_q;
  logic              is_full;
  logic              do_pop, do_push, do_drop;

  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;
  assign cmd_take_o = !cmd_empty_i && (!out_valid_q || pop_i);
  assign is_full    = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign do_pop     = cmd_take_o && cmd_i.is_pop && (cnt_q != '0);
  assign do_push    = cmd_take_o && !cmd_i.is_pop && !is_full;
  assign do_drop    = cmd_take_o && !cmd_i.is_pop && is_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q        <= '0;
      wr_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (do_pop) begin
        rd_q  <= (rd_q == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end
      if (do_push) begin
        wr_q  <= (wr_q == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_take_o) begin
        out_valid_q <= do_pop || do_drop;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= cmd_i.rec;
    end
    if (do_pop) begin
      out_q <= {KIND_POP, store_q[rd_q], to_fill(cnt_q - 1'b1)};
    end else if (do_drop) begin
      out_q <= {KIND_DROP, cmd_i.rec, to_fill(cnt_q)};
    end
  end

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("record count exceeds depth");
  a_slots_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_q < SLOT_W'(FIFO_DEPTH)) && (wr_q < SLOT_W'(FIFO_DEPTH)))
    else $error("slot pointer out of range");
  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_drop |=> (out_valid_q && out_q.kind == KIND_DROP && is_full))
    else $error("drop notice without full store");
`endif

endmodule

// ----- rtl/core/header_sync_record_deframer_fifo_core.sv -----
`timescale 1ns / 1ps
// Sync-word deframer with a record FIFO.
// Input channel (push/full, item_i): each beat is either a received serial
// byte (func = 0) or a pop request (func = 1). The byte path hunts for 0xAA
// followed directly by 0x55, then gathers a fixed-size payload into a
// record that is stored in a ring FIFO of FIFO_DEPTH records.
// Result channel (empty/pop, result_o): a pop request yields the oldest
// record (kind 0) unless the FIFO is empty; a record arriving while the
// FIFO is full yields a drop notice (kind 1) carrying that record.
// fill_level is the record count after the beat.
// Throughput: one input beat per cycle while full is low. The front decoder
// registers each command into a two-entry queue; the back end retires one
// command per cycle while its single output register is empty or popped, so
// a result passes through the queue entry and then the output register.
// If the receiver holds pop low, the output register stays loaded, the
// queue fills and full rises after two more command beats; byte beats that
// do not finish a record are still taken while the queue has room.
// Reset clears the framing state, the FIFO pointers and the count; record
// contents are not cleared.
module header_sync_record_deframer_fifo_core
  import hsrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_beat_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_beat_t result_o
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_take;

  assign accept = push && !full;

  hsrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd_in)
  );

  hsrd_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_valid),
    .wr_data_i(cmd_in),
    .full_o   (full),
    .rd_en_i  (cmd_take),
    .rd_data_o(cmd_head),
    .empty_o  (cmd_empty)
  );

  hsrd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_take_o (cmd_take),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule

// ----- tb/header_sync_record_deframer_fifo_core_tb.sv -----
`timescale 1ns / 1ps
module header_sync_record_deframer_fifo_core_tb;
  import hsrd_pkg::*;

  typedef enum logic [1:0] {ST_BYTE, ST_POP, ST_FRAME, ST_BODY} step_e;
  typedef enum logic [1:0] {PAT_CONST, PAT_RAMP, PAT_RAND} pattern_e;

  typedef struct packed {
    step_e      op;
    pattern_e   pat;
    logic [7:0] val;
    logic [3:0] reps;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  localparam int unsigned RAND_BEATS = 940;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);

  localparam out_beat_t NO_WANT = '0;
  localparam out_beat_t ZERO_POP = '{KIND_POP, 16'h0, 32'h0, 32'h0, 32'h0, 48'h0, 4'd0};
  localparam out_beat_t ONES_POP = '{KIND_POP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'd0};
  localparam out_beat_t ZERO_DROP = '{KIND_DROP, 16'h0, 32'h0, 32'h0, 32'h0, 48'h0, FILL_FULL};
  localparam out_beat_t ONES_DROP = '{KIND_DROP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, FILL_FULL};

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},   // pop on empty
    '{ST_BYTE,  PAT_CONST, 8'h55, 4'd1,  1'b0, NO_WANT},
    '{ST_BYTE,  PAT_CONST, 8'hAA, 4'd1,  1'b0, NO_WANT},
    '{ST_BYTE,  PAT_CONST, 8'hAA, 4'd1,  1'b0, NO_WANT},   // bad second sync, not rechecked
    '{ST_BYTE,  PAT_CONST, 8'h55, 4'd1,  1'b0, NO_WANT},
    '{ST_FRAME, PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b1, ZERO_POP},
    '{ST_FRAME, PAT_CONST, 8'hFF, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'hFF, 4'd1,  1'b1, ONES_POP},
    '{ST_FRAME, PAT_RAMP,  8'h10, 4'd1,  1'b0, NO_WANT},
    '{ST_BYTE,  PAT_CONST, 8'hAA, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},   // pop while framing
    '{ST_BYTE,  PAT_CONST, 8'h55, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},   // empty, in payload
    '{ST_BODY,  PAT_RAMP,  8'h80, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},
    '{ST_FRAME, PAT_RAMP,  8'h20, 4'd10, 1'b0, NO_WANT},   // fill up
    '{ST_FRAME, PAT_CONST, 8'hFF, 4'd1,  1'b1, ONES_DROP},
    '{ST_FRAME, PAT_CONST, 8'h00, 4'd1,  1'b1, ZERO_DROP},
    '{ST_BYTE,  PAT_CONST, 8'hAA, 4'd1,  1'b0, NO_WANT},
    '{ST_BYTE,  PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},
    '{ST_POP,   PAT_CONST, 8'hFF, 4'd10, 1'b0, NO_WANT},   // drain
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT},
    '{ST_FRAME, PAT_RAMP,  8'hA0, 4'd1,  1'b0, NO_WANT},   // first sync value inside payload
    '{ST_POP,   PAT_CONST, 8'h00, 4'd1,  1'b0, NO_WANT}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_beat_t  item_i = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t result_o;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int beats_in = 0;

  // predictor state
  phase_e     hunt_state = PH_HUNT;
  int         gather_idx = 0;
  logic [7:0] frame_bytes [PAYLOAD_BYTES];
  rec_t       held_records [$];
  out_beat_t  due_results [$];

  header_sync_record_deframer_fifo_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit deframe_beat(input in_beat_t b, output out_beat_t r);
    rec_t rec;
    r = '0;
    if (b.func == FUNC_POP) begin
      if (held_records.size() == 0) return 1'b0;
      rec = held_records.pop_front();
      r = {KIND_POP, rec, FILL_W'(held_records.size())};
      return 1'b1;
    end
    case (hunt_state)
      PH_SYNC2: begin
        hunt_state = (b.rx_byte == SYNC_SECOND) ? PH_GATHER : PH_HUNT;
        gather_idx = 0;
        return 1'b0;
      end
      PH_GATHER: begin
        if (gather_idx < PAYLOAD_BYTES) frame_bytes[gather_idx] = b.rx_byte;
        gather_idx++;
        if (gather_idx < PAYLOAD_BYTES) return 1'b0;
        hunt_state = PH_HUNT;
        gather_idx = 0;
        rec.charge_level = {frame_bytes[1], frame_bytes[0]};
        rec.speed_bits = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4]};
        rec.odometer_bits = {frame_bytes[11], frame_bytes[10], frame_bytes[9], frame_bytes[8]};
        rec.shown_speed_bits = {frame_bytes[15], frame_bytes[14], frame_bytes[13],
                                frame_bytes[12]};
        rec.station_address = {frame_bytes[16], frame_bytes[17], frame_bytes[18],
                               frame_bytes[19], frame_bytes[20], frame_bytes[21]};
        if (held_records.size() >= FIFO_DEPTH) begin
          r = {KIND_DROP, rec, FILL_W'(held_records.size())};
          return 1'b1;
        end
        held_records.push_back(rec);
        return 1'b0;
      end
      default: begin
        hunt_state = (b.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t got;
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (deframe_beat(b, got)) due_results.push_back(typed ? want : got);
    beats_in++;
  endtask

  function automatic in_beat_t pop_beat();
    return in_beat_t'({FUNC_POP, 8'($urandom_range(0, 255))});
  endfunction

  // sync word (optional) plus payload; random frames may carry a pop before or inside
  task automatic send_frame(input bit with_sync, input pattern_e pat, input logic [7:0] v,
                            input bit typed, input out_beat_t want);
    logic [7:0] d;
    int pop_at;
    pop_at = (pat == PAT_RAND && $urandom_range(0, 4) == 0) ?
             int'($urandom_range(0, PAYLOAD_BYTES + 1)) : -1;
    for (int j = with_sync ? 0 : 2; j < PAYLOAD_BYTES + 2; j++) begin
      if (j == pop_at) send_beat(pop_beat(), 1'b0, NO_WANT);
      if (j == 0) d = SYNC_FIRST;
      else if (j == 1) d = SYNC_SECOND;
      else if (pat == PAT_CONST) d = v;
      else if (pat == PAT_RAMP) d = v + 8'(j - 2);
      else d = 8'($urandom_range(0, 255));
      send_beat(in_beat_t'({FUNC_BYTE, d}), typed && j == PAYLOAD_BYTES + 1, want);
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && pop && !empty) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected beat, expected none, got %h", $time, result_o);
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, result_o.kind);
        check_field("charge_level", want.charge_level, result_o.charge_level);
        check_field("speed_bits", want.speed_bits, result_o.speed_bits);
        check_field("odometer_bits", want.odometer_bits, result_o.odometer_bits);
        check_field("shown_speed_bits", want.shown_speed_bits, result_o.shown_speed_bits);
        check_field("station_address", want.station_address, result_o.station_address);
        check_field("fill_level", want.fill_level, result_o.fill_level);
      end
    end
  end

  // result side
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int start;
    int n;
    int pick;
    bit drain;
    bit held_once;
    logic [7:0] x;
    held_once = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      for (int k = 0; k < int'(DIR_TAB[r].reps); k++) begin
        case (DIR_TAB[r].op)
          ST_BYTE: send_beat(in_beat_t'({FUNC_BYTE, DIR_TAB[r].val}), DIR_TAB[r].typed,
                             DIR_TAB[r].want);
          ST_POP: send_beat(in_beat_t'({FUNC_POP, DIR_TAB[r].val}), DIR_TAB[r].typed,
                            DIR_TAB[r].want);
          default: send_frame(DIR_TAB[r].op == ST_FRAME, DIR_TAB[r].pat,
                              DIR_TAB[r].val + 8'(k * 24), DIR_TAB[r].typed, DIR_TAB[r].want);
        endcase
      end
    end

    // random part: alternating fill-heavy and drain-heavy stretches
    start = beats_in;
    while (beats_in - start < RAND_BEATS) begin
      n = beats_in - start;
      drain = ((n / 200) % 2) == 1;
      if (n >= RAND_BEATS * 85 / 100) calm = 1'b1;
      if (!held_once && drain && n >= 520) begin
        hold_req = 1'b1;
        held_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < (drain ? 30 : 55)) begin
        send_frame(1'b1, PAT_RAND, 8'h00, 1'b0, NO_WANT);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, drain ? 6 : 2)) send_beat(pop_beat(), 1'b0, NO_WANT);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) begin
          x = ($urandom_range(0, 3) == 0) ? SYNC_SECOND : 8'($urandom_range(0, 255));
          send_beat(in_beat_t'({FUNC_BYTE, x}), 1'b0, NO_WANT);
        end
      end else begin
        send_beat(in_beat_t'({FUNC_BYTE, SYNC_FIRST}), 1'b0, NO_WANT);
        if ($urandom_range(0, 1) == 0) begin
          x = 8'($urandom_range(0, 255));
          if (x == SYNC_SECOND) x = x + 8'd1;
          send_beat(in_beat_t'({FUNC_BYTE, x}), 1'b0, NO_WANT);
        end else begin
          send_beat(in_beat_t'({FUNC_BYTE, SYNC_FIRST}), 1'b0, NO_WANT);
          send_beat(in_beat_t'({FUNC_BYTE, SYNC_SECOND}), 1'b0, NO_WANT);
        end
      end
    end

    calm = 1'b1;
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hsrd_pkg.sv
rtl/core/hsrd_front.sv
rtl/core/hsrd_cmd_queue.sv
rtl/core/hsrd_back.sv
rtl/core/header_sync_record_deframer_fifo_core.sv
tb/header_sync_record_deframer_fifo_core_tb.sv
